// File: sv/iofrb_pkg.sv
// Shared constants, types and job descriptor for the frame receiver.
package iofrb_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int NUM_CARDS   = 16;
    localparam int CARD_AW     = (NUM_CARDS > 1) ? $clog2(NUM_CARDS) : 1;

    localparam logic [4:0] MAX_LEN      = 5'(MAX_PAYLOAD);
    localparam logic [4:0] CARD_LIMIT   = 5'(NUM_CARDS);
    localparam logic [4:0] LEN_FLAG_SET = 5'd6;
    localparam logic [4:0] LEN_FLAG_CLR = 5'd1;
    localparam logic [4:0] LEN_WORD     = 5'd2;
    localparam logic [1:0] CODE_INPUT   = 2'd0;
    localparam logic [7:0] CLEAR_CMD    = 8'h06;
    localparam logic [4:0] BUTTON_OFS   = 5'd16;

    localparam logic EV_BUTTON = 1'b0;
    localparam logic EV_FLAG   = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR1  = 4'b0001,
        PH_HDR2  = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        logic               flag_go;
        logic               card_go;
        logic               flags;
        logic [CARD_AW-1:0] card;
        logic               card_zero;
        logic [15:0]        word;
    } job_t;

endpackage

// File: sv/iofrb_card_ram.sv
// Single-port read-first synchronous RAM holding the card input words.
module iofrb_card_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: sv/iofrb_parser.sv
// Byte deframer: header, descriptor, payload and check byte, and frame decode.
module iofrb_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              busy,
    output iofrb_pkg::job_t   job
);

    iofrb_pkg::phase_t phase_reg, phase_next;
    logic [7:0] header_reg, header_next;
    logic [6:0] sum_reg, sum_next;
    logic [1:0] code_reg, code_next;
    logic [4:0] len_reg, len_next;
    logic [4:0] count_reg, count_next;
    logic [7:0] pay0_reg, pay1_reg;
    logic       clear_reg, clear_next;
    logic       take;
    logic       check_ok;
    logic [4:0] count_inc;

    // Hold check bytes while the previous frame's events drain.
    assign in_ready  = !((phase_reg == iofrb_pkg::PH_CHECK) && busy);
    assign take      = in_valid && in_ready;
    assign check_ok  = ({1'b0, ~sum_reg} == rx_byte);
    assign count_inc = count_reg + 5'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        sum_next    = sum_reg;
        code_next   = code_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        if (take)
        begin
            unique case (phase_reg)
                iofrb_pkg::PH_HDR1:
                begin
                    if (rx_byte[7])
                    begin
                        header_next = rx_byte;
                        sum_next    = rx_byte[6:0];
                        phase_next  = iofrb_pkg::PH_HDR2;
                    end
                end
                iofrb_pkg::PH_HDR2:
                begin
                    if (rx_byte[7])
                    begin
                        header_next = rx_byte;
                        sum_next    = rx_byte[6:0];
                    end
                    else
                    begin
                        code_next = rx_byte[6:5];
                        len_next  = rx_byte[4:0];
                        sum_next  = sum_reg + rx_byte[6:0];
                        if (rx_byte[4:0] == 5'd0 || rx_byte[4:0] > iofrb_pkg::MAX_LEN)
                        begin
                            phase_next = iofrb_pkg::PH_CHECK;
                        end
                        else
                        begin
                            count_next = 5'd0;
                            phase_next = iofrb_pkg::PH_DATA;
                        end
                    end
                end
                iofrb_pkg::PH_DATA:
                begin
                    sum_next   = sum_reg + rx_byte[6:0];
                    count_next = count_inc;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = iofrb_pkg::PH_CHECK;
                    end
                end
                iofrb_pkg::PH_CHECK:
                begin
                    phase_next = iofrb_pkg::PH_HDR1;
                end
                default:
                begin
                    phase_next = iofrb_pkg::PH_HDR1;
                end
            endcase
        end
    end

    always_comb
    begin
        job           = '0;
        job.card      = header_reg[iofrb_pkg::CARD_AW-1:0];
        job.card_zero = (header_reg[3:0] == 4'd0);
        job.word      = {pay1_reg, pay0_reg};
        if (take && phase_reg == iofrb_pkg::PH_CHECK && check_ok
            && code_reg == iofrb_pkg::CODE_INPUT)
        begin
            if (len_reg == iofrb_pkg::LEN_FLAG_SET)
            begin
                job.flag_go = (pay0_reg != 8'd0) && !clear_reg;
            end
            else if (len_reg == iofrb_pkg::LEN_FLAG_CLR && pay0_reg == iofrb_pkg::CLEAR_CMD)
            begin
                job.flag_go = clear_reg;
            end
            else if (len_reg == iofrb_pkg::LEN_WORD)
            begin
                job.card_go = ({1'b0, header_reg[3:0]} < iofrb_pkg::CARD_LIMIT);
            end
        end
        clear_next = job.flag_go ? !clear_reg : clear_reg;
        job.flags  = clear_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= iofrb_pkg::PH_HDR1;
            header_reg <= 8'd0;
            sum_reg    <= 7'd0;
            code_reg   <= 2'd0;
            len_reg    <= 5'd0;
            count_reg  <= 5'd0;
            clear_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            sum_reg    <= sum_next;
            code_reg   <= code_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            clear_reg  <= clear_next;
        end
    end

    // Only the first two payload bytes are ever decoded.
    always_ff @(posedge clk)
    begin
        if (take && phase_reg == iofrb_pkg::PH_DATA)
        begin
            if (count_reg == 5'd0)
            begin
                pay0_reg <= rx_byte;
            end
            if (count_reg == 5'd1)
            begin
                pay1_reg <= rx_byte;
            end
        end
    end

endmodule

// File: sv/iofrb_event_gen.sv
// Rising-edge extraction against the card store and one-per-cycle event output while out_ready is high.
module iofrb_event_gen (
    input  logic              clk,
    input  logic              rst_n,
    input  iofrb_pkg::job_t   job,
    input  logic [15:0]       rd_word,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              event_kind,
    output logic [4:0]        button_number,
    output logic              flags_pending,
    output logic              last_event
);

    logic        card_vld_reg [iofrb_pkg::NUM_CARDS];
    logic        pend_reg;
    logic        pend_zero_reg;
    logic [15:0] pend_word_reg;
    logic        pend_old_reg;
    logic [15:0] mask_reg, mask_next;
    logic        mask_zero_reg;
    logic        flag_pend_reg;
    logic        flags_reg;
    logic        out_valid_reg;
    logic        kind_reg;
    logic [4:0]  button_reg;
    logic        pending_reg;
    logic        last_reg;
    logic        slot_free;
    logic [15:0] low_bit;
    logic [15:0] mask_rest;
    logic [3:0]  low_idx;
    logic [15:0] fresh_mask;

    assign busy       = pend_reg || flag_pend_reg || (mask_reg != 16'd0);
    assign slot_free  = !out_valid_reg || out_ready;
    assign low_bit    = mask_reg & (~mask_reg + 16'd1);
    assign mask_rest  = mask_reg & ~low_bit;
    assign fresh_mask = pend_word_reg & ~(pend_old_reg ? rd_word : 16'd0);

    always_comb
    begin
        low_idx = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | 4'(i);
            end
        end
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (pend_reg)
        begin
            mask_next = fresh_mask;
        end
        else if (slot_free && !flag_pend_reg)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iofrb_pkg::NUM_CARDS; i++)
            begin
                card_vld_reg[i] <= 1'b0;
            end
            pend_reg      <= 1'b0;
            flag_pend_reg <= 1'b0;
            mask_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= job.card_go;
            if (job.card_go)
            begin
                card_vld_reg[job.card] <= 1'b1;
            end
            mask_reg <= mask_next;
            if (job.flag_go)
            begin
                flag_pend_reg <= 1'b1;
            end
            else if (slot_free)
            begin
                flag_pend_reg <= 1'b0;
            end
            if (slot_free)
            begin
                out_valid_reg <= flag_pend_reg || (!pend_reg && mask_reg != 16'd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.card_go)
        begin
            pend_zero_reg <= job.card_zero;
            pend_word_reg <= job.word;
            pend_old_reg  <= card_vld_reg[job.card];
        end
        if (job.card_go || job.flag_go)
        begin
            flags_reg <= job.flags;
        end
        if (pend_reg)
        begin
            mask_zero_reg <= pend_zero_reg;
        end
        if (slot_free)
        begin
            if (flag_pend_reg)
            begin
                kind_reg    <= iofrb_pkg::EV_FLAG;
                button_reg  <= 5'd0;
                pending_reg <= flags_reg;
                last_reg    <= 1'b1;
            end
            else
            begin
                kind_reg    <= iofrb_pkg::EV_BUTTON;
                button_reg  <= mask_zero_reg ? {1'b0, low_idx}
                                             : ({1'b0, low_idx} + iofrb_pkg::BUTTON_OFS);
                pending_reg <= flags_reg;
                last_reg    <= (mask_rest == 16'd0);
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign button_number = button_reg;
    assign flags_pending = pending_reg;
    assign last_event    = last_reg;

`ifndef SYNTHESIS
    a_job_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (job.card_go || job.flag_go) |-> !busy)
        else $error("new job issued while events still pending");

    a_one_job_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(job.card_go && job.flag_go))
        else $error("flag and card job issued together");

    a_pend_alone: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (!flag_pend_reg && mask_reg == 16'd0))
        else $error("card read overlaps another job");

    a_flag_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == iofrb_pkg::EV_FLAG) |-> last_reg)
        else $error("flag event not marked last");
`endif

endmodule

// File: sv/io_frame_receiver_button_edges.sv
// Top level: serial frame receiver emitting button-edge and clear-flags events.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  input   | in_valid / in_ready  | rx_byte
//  output  | out_valid / out_ready| event_kind, button_number, flags_pending, last_event
//
// One byte is taken per cycle. A check byte is held back while events of the previous
// frame are still waiting to enter the output register; events leave one per cycle
// while out_ready is high. A card frame's events pass from its check byte through the
// card store read and the event mask to the output register, a flag frame's through
// the flag request. Reset clears the parser, the clear-flags request and the card valid
// bits; no clearing pass is needed. Output stalls back up only into check bytes.
module io_frame_receiver_button_edges (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       event_kind,
    output logic [4:0] button_number,
    output logic       flags_pending,
    output logic       last_event
);

    iofrb_pkg::job_t job;
    logic            busy;
    logic [15:0]     rd_word;

    iofrb_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .busy     (busy),
        .job      (job)
    );

    // Read the old word and write the new one in the same cycle.
    iofrb_card_ram #(
        .DEPTH (iofrb_pkg::NUM_CARDS),
        .AW    (iofrb_pkg::CARD_AW),
        .WIDTH (16)
    ) u_card_ram (
        .clk   (clk),
        .we    (job.card_go),
        .addr  (job.card),
        .wdata (job.word),
        .rdata (rd_word)
    );

    iofrb_event_gen u_event_gen (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (job),
        .rd_word       (rd_word),
        .busy          (busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .button_number (button_number),
        .flags_pending (flags_pending),
        .last_event    (last_event)
    );

endmodule
